### rtl/nearest_vertex_search_assert.svh
// ----------------------------------------------------------------------------
// nearest_vertex_search assertion macros
// Shared property forms for the port checker; all sample on aclk.
// ----------------------------------------------------------------------------
`ifndef NEAREST_VERTEX_SEARCH_ASSERT_SVH
`define NEAREST_VERTEX_SEARCH_ASSERT_SVH

// same-cycle implication, off during reset
`define NVS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nearest_vertex_search: port check failed");

// next-cycle implication, off during reset
`define NVS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nearest_vertex_search: port check failed");

// state right after a reset cycle
`define NVS_ASSERT_RESET(lbl, cons) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error("nearest_vertex_search: reset check failed");

`endif

### rtl/nvs_pkg.sv
// ----------------------------------------------------------------------------
// nvs_pkg
// Constants, codes and types shared by the nearest vertex search modules.
// ----------------------------------------------------------------------------
`default_nettype none

package nvs_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int COORD_WIDTH  = 20;

    localparam int IDX_W   = 8;
    localparam int CNT_W   = 9;
    localparam int ADDR_W  = $clog2(MAX_VERTICES);
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int DIST_W  = SQ_W + 2;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_MODE = 1'd1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic MODE_MANHATTAN = 1'b0;
    localparam logic MODE_EUCLIDEAN = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vertex_t;

    typedef struct packed {
        logic             is_query;
        logic [IDX_W-1:0] idx;
        vertex_t          pos;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

### rtl/nvs_front.sv
// ----------------------------------------------------------------------------
// nvs_front
// Input stage: takes beats, tags loads and queries, and hands items to the
// command queue; an 8-bit index is always inside the table, so no load drops.
// ----------------------------------------------------------------------------
`default_nettype none

module nvs_front (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire                           s_command,
    input  wire  [nvs_pkg::IDX_W-1:0]     s_entry_index,
    input  wire  signed [nvs_pkg::COORD_WIDTH-1:0] s_coord_x,
    input  wire  signed [nvs_pkg::COORD_WIDTH-1:0] s_coord_y,
    input  wire  signed [nvs_pkg::COORD_WIDTH-1:0] s_coord_z,
    input  nvs_pkg::q_status_t            q_stat,
    output logic                          q_push,
    output nvs_pkg::item_t                q_item
);

    logic           hold_vld_reg;
    nvs_pkg::item_t hold_item_reg;
    logic           s_fire;
    logic           keep;

    assign q_push  = hold_vld_reg && !q_stat.full;
    assign s_ready = !hold_vld_reg || !q_stat.full;
    assign s_fire  = s_valid && s_ready;
    assign q_item  = hold_item_reg;

    assign keep = (s_command == nvs_pkg::CMD_QUERY) ||
                  ({1'b0, s_entry_index} < nvs_pkg::CNT_W'(nvs_pkg::MAX_VERTICES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
        end else if (s_fire) begin
            hold_vld_reg <= keep;
        end else if (q_push) begin
            hold_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            hold_item_reg.is_query <= (s_command == nvs_pkg::CMD_QUERY);
            hold_item_reg.idx      <= s_entry_index;
            hold_item_reg.pos.x    <= s_coord_x;
            hold_item_reg.pos.y    <= s_coord_y;
            hold_item_reg.pos.z    <= s_coord_z;
        end
    end

endmodule

`default_nettype wire

### rtl/nvs_fifo.sv
// ----------------------------------------------------------------------------
// nvs_fifo
// Short command queue between the input stage and the scan engine.
// ----------------------------------------------------------------------------
`default_nettype none

module nvs_fifo (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  nvs_pkg::item_t      push_item,
    input  wire                 pop,
    output nvs_pkg::item_t      pop_item,
    output nvs_pkg::q_status_t  stat
);

    nvs_pkg::item_t                entry_reg [nvs_pkg::FIFO_DEPTH];
    logic [nvs_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [nvs_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [nvs_pkg::FIFO_AW:0]     count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign stat.full  = (count_reg == (nvs_pkg::FIFO_AW+1)'(nvs_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### rtl/nvs_back.sv
// ----------------------------------------------------------------------------
// nvs_back
// Scan engine: owns the vertex table, writes loads, and runs each query as a
// one-entry-per-cycle pipeline (read, difference, square in Euclidean mode, sum, compare).
// ----------------------------------------------------------------------------
`default_nettype none

module nvs_back (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  nvs_pkg::item_t                q_item,
    input  nvs_pkg::q_status_t            q_stat,
    output logic                          q_pop,
    input  wire  [nvs_pkg::CNT_W-1:0]     cfg_count,
    input  wire                           cfg_mode,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [nvs_pkg::IDX_W-1:0]     m_nearest_index
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    nvs_pkg::vertex_t mem [nvs_pkg::MAX_VERTICES];

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;

    nvs_pkg::vertex_t              query_reg;
    logic                          mode_reg;
    logic [nvs_pkg::CNT_W-1:0]     limit_reg;
    logic [nvs_pkg::CNT_W-1:0]     issue_cnt_reg;

    logic                          a_vld_reg;
    logic [nvs_pkg::ADDR_W-1:0]    a_idx_reg;
    nvs_pkg::vertex_t              rd_data_reg;

    logic                          b_vld_reg;
    logic [nvs_pkg::ADDR_W-1:0]    b_idx_reg;
    logic [nvs_pkg::DIFF_W-1:0]    dx_reg;
    logic [nvs_pkg::DIFF_W-1:0]    dy_reg;
    logic [nvs_pkg::DIFF_W-1:0]    dz_reg;

    logic                          c_vld_reg;
    logic [nvs_pkg::ADDR_W-1:0]    c_idx_reg;
    logic [nvs_pkg::SQ_W-1:0]      sx_reg;
    logic [nvs_pkg::SQ_W-1:0]      sy_reg;
    logic [nvs_pkg::SQ_W-1:0]      sz_reg;

    logic                          d_vld_reg;
    logic [nvs_pkg::ADDR_W-1:0]    d_idx_reg;
    logic [nvs_pkg::DIST_W-1:0]    dist_reg;

    logic                          have_reg;
    logic [nvs_pkg::DIST_W-1:0]    best_d_reg;
    logic [nvs_pkg::IDX_W-1:0]     best_idx_reg;

    logic                          m_valid_reg;
    logic [nvs_pkg::IDX_W-1:0]     m_index_reg;

    logic                          start;
    logic                          mem_we;
    logic                          rd_en;
    logic                          scan_done;
    logic                          out_load;
    logic                          better;
    logic [nvs_pkg::CNT_W-1:0]     limit;
    logic [nvs_pkg::DIFF_W-1:0]    abs_x;
    logic [nvs_pkg::DIFF_W-1:0]    abs_y;
    logic [nvs_pkg::DIFF_W-1:0]    abs_z;

    function automatic logic [nvs_pkg::DIFF_W-1:0] abs_diff(
        input nvs_pkg::coord_t a,
        input nvs_pkg::coord_t b
    );
        logic signed [nvs_pkg::DIFF_W-1:0] d;
        d = {a[nvs_pkg::COORD_WIDTH-1], a} - {b[nvs_pkg::COORD_WIDTH-1], b};
        return d[nvs_pkg::DIFF_W-1] ? nvs_pkg::DIFF_W'(-d) : nvs_pkg::DIFF_W'(d);
    endfunction

    assign limit = (cfg_count > nvs_pkg::CNT_W'(nvs_pkg::MAX_VERTICES)) ?
                   nvs_pkg::CNT_W'(nvs_pkg::MAX_VERTICES) : cfg_count;

    assign abs_x = abs_diff(rd_data_reg.x, query_reg.x);
    assign abs_y = abs_diff(rd_data_reg.y, query_reg.y);
    assign abs_z = abs_diff(rd_data_reg.z, query_reg.z);

    assign better    = d_vld_reg && (!have_reg || (dist_reg < best_d_reg));
    assign scan_done = (issue_cnt_reg == limit_reg) &&
                       !a_vld_reg && !b_vld_reg && !c_vld_reg && !d_vld_reg;

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        start      = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop = 1'b1;
                    if (q_item.is_query) begin
                        start      = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        mem_we = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                rd_en = (issue_cnt_reg < limit_reg);
                if (scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            a_vld_reg <= rd_en;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[q_item.idx[nvs_pkg::ADDR_W-1:0]] <= q_item.pos;
        end
        if (rd_en) begin
            rd_data_reg <= mem[issue_cnt_reg[nvs_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            query_reg     <= q_item.pos;
            mode_reg      <= cfg_mode;
            limit_reg     <= limit;
            issue_cnt_reg <= '0;
        end else if (rd_en) begin
            issue_cnt_reg <= issue_cnt_reg + 1'b1;
        end

        a_idx_reg <= issue_cnt_reg[nvs_pkg::ADDR_W-1:0];

        b_idx_reg <= a_idx_reg;
        dx_reg    <= abs_x;
        dy_reg    <= abs_y;
        dz_reg    <= abs_z;

        c_idx_reg <= b_idx_reg;
        if (mode_reg == nvs_pkg::MODE_EUCLIDEAN) begin
            sx_reg <= dx_reg * dx_reg;
            sy_reg <= dy_reg * dy_reg;
            sz_reg <= dz_reg * dz_reg;
        end else begin
            sx_reg <= nvs_pkg::SQ_W'(dx_reg);
            sy_reg <= nvs_pkg::SQ_W'(dy_reg);
            sz_reg <= '0;
        end

        d_idx_reg <= c_idx_reg;
        dist_reg  <= nvs_pkg::DIST_W'(sx_reg) + nvs_pkg::DIST_W'(sy_reg) +
                     nvs_pkg::DIST_W'(sz_reg);

        if (start) begin
            have_reg     <= 1'b0;
            best_idx_reg <= '0;
        end else if (better) begin
            have_reg     <= 1'b1;
            best_d_reg   <= dist_reg;
            best_idx_reg <= nvs_pkg::IDX_W'(d_idx_reg);
        end

        if (out_load) begin
            m_index_reg <= best_idx_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_nearest_index = m_index_reg;

endmodule

`default_nettype wire

### rtl/nearest_vertex_search.sv
// ----------------------------------------------------------------------------
// nearest_vertex_search
// Nearest-vertex linear scan over a 256-entry coordinate table, Manhattan 2D
// or squared Euclidean 3D distance, lowest index wins ties.
// ----------------------------------------------------------------------------
//  channel   ports                                   beat
//  s_        s_valid/s_ready, command, index, x/y/z   load or query item
//  m_        m_valid/m_ready, m_nearest_index         one per query
//  cfg_      cfg_we, cfg_index, cfg_wdata             register write
//
//  A load is written to the table while the scan engine stays idle; a query
//  reads min(vertex_count, 256) entries, none when vertex_count is 0, through
//  the single table read port, one entry per cycle, into a 4-stage pipe.
//  Synchronous active-low reset clears control and config; the table is not
//  cleared. A 2-deep queue sits between the input stage and the scan engine,
//  so s_ takes beats while a query scans or a result stalls on m_ until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_vertex_search (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire                                   s_command,
    input  wire  [nvs_pkg::IDX_W-1:0]             s_entry_index,
    input  wire  signed [nvs_pkg::COORD_WIDTH-1:0] s_coord_x,
    input  wire  signed [nvs_pkg::COORD_WIDTH-1:0] s_coord_y,
    input  wire  signed [nvs_pkg::COORD_WIDTH-1:0] s_coord_z,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic [nvs_pkg::IDX_W-1:0]             m_nearest_index,
    input  wire                                   cfg_we,
    input  wire  [nvs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire  [nvs_pkg::CNT_W-1:0]             cfg_wdata
);

    logic [nvs_pkg::CNT_W-1:0] vertex_count_reg;
    logic                      distance_mode_reg;

    nvs_pkg::q_status_t        q_stat;
    nvs_pkg::item_t            push_item;
    nvs_pkg::item_t            pop_item;
    logic                      q_push;
    logic                      q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg  <= '0;
            distance_mode_reg <= nvs_pkg::MODE_MANHATTAN;
        end else if (cfg_we) begin
            unique case (cfg_index)
                nvs_pkg::CFG_VERTEX_COUNT:  vertex_count_reg  <= cfg_wdata;
                nvs_pkg::CFG_DISTANCE_MODE: distance_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    nvs_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_entry_index (s_entry_index),
        .s_coord_x     (s_coord_x),
        .s_coord_y     (s_coord_y),
        .s_coord_z     (s_coord_z),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    nvs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .stat      (q_stat)
    );

    nvs_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_item          (pop_item),
        .q_stat          (q_stat),
        .q_pop           (q_pop),
        .cfg_count       (vertex_count_reg),
        .cfg_mode        (distance_mode_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_nearest_index (m_nearest_index)
    );

endmodule

`default_nettype wire

### rtl/nvs_checker.sv
// ----------------------------------------------------------------------------
// nvs_checker
// Port-level checks for nearest_vertex_search, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_vertex_search_assert.svh"

module nvs_checker (
    input wire                               aclk,
    input wire                               aresetn,
    input wire                               s_valid,
    input wire                               s_ready,
    input wire                               s_command,
    input wire                               m_valid,
    input wire                               m_ready,
    input wire [nvs_pkg::IDX_W-1:0]          m_nearest_index,
    input wire                               cfg_we,
    input wire [nvs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input wire [nvs_pkg::CNT_W-1:0]          cfg_wdata
);

    localparam int PEND_W = 3;

    logic [PEND_W-1:0]         pending_reg;
    logic [nvs_pkg::CNT_W-1:0] count_reg;
    logic                      query_in;
    logic                      result_out;

    assign query_in   = s_valid && s_ready && (s_command == nvs_pkg::CMD_QUERY);
    assign result_out = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            count_reg   <= '0;
        end else begin
            if (query_in && !result_out) begin
                pending_reg <= pending_reg + 1'b1;
            end else if (result_out && !query_in) begin
                pending_reg <= pending_reg - 1'b1;
            end
            if (cfg_we && (cfg_index == nvs_pkg::CFG_VERTEX_COUNT)) begin
                count_reg <= cfg_wdata;
            end
        end
    end

    `NVS_ASSERT_RESET(a_reset_idle, !m_valid)
    `NVS_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_nearest_index))
    `NVS_ASSERT_NOW(a_result_has_query, m_valid, pending_reg != '0)
    `NVS_ASSERT_NOW(a_index_in_table, m_valid, (m_nearest_index == '0) || ({1'b0, m_nearest_index} < count_reg))

endmodule

bind nearest_vertex_search nvs_checker u_nvs_checker (.*);

`default_nettype wire
